>>> rtl/core/chp_pkg.sv
// Shared types and constants for the camera health persistence filter.
package chp_pkg;

	// Issue codes seen on a frame and reported as the active issue
	typedef enum logic [1:0] {
		ISSUE_NONE        = 2'd0,
		ISSUE_OBSTRUCTION = 2'd1,
		ISSUE_BLUR        = 2'd2
	} issue_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUR_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERSIST      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR        = 3'd5;

	localparam int unsigned TS_W    = 48;
	localparam int unsigned RATIO_W = 17;
	localparam int unsigned VAR_W   = 32;
	localparam int unsigned MS_W    = 24;
	localparam int unsigned CNT_W   = 16;

	// Reset value of the ratio limits: 1.0 in Q1.16
	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

	typedef struct packed {
		logic [MS_W-1:0]    interval_ms;
		logic [RATIO_W-1:0] dark_limit;
		logic [RATIO_W-1:0] bright_limit;
		logic [VAR_W-1:0]   blur_limit;
		logic [MS_W-1:0]    persist_ms;
		logic [MS_W-1:0]    clear_ms;
	} cfg_t;

	typedef struct packed {
		logic               frame_present;
		logic               has_pixels;
		logic [TS_W-1:0]    timestamp_ms;
		logic [RATIO_W-1:0] dark_ratio;
		logic [RATIO_W-1:0] bright_ratio;
		logic [VAR_W-1:0]   laplacian_variance;
	} frame_t;

	typedef struct packed {
		logic               status_valid;
		issue_t             active_issue;
		logic [CNT_W-1:0]   suspect_frames;
		logic [RATIO_W-1:0] dark_ratio_out;
		logic [RATIO_W-1:0] bright_ratio_out;
		logic [VAR_W-1:0]   variance_out;
	} status_t;

endpackage

>>> rtl/core/chp_ifs.sv
// Channel interfaces: frame statistics in, status out, configuration writes.
interface chp_frame_if;
	logic        valid;
	logic        ready;
	logic        frame_present;
	logic        has_pixels;
	logic [47:0] timestamp_ms;
	logic [16:0] dark_ratio;
	logic [16:0] bright_ratio;
	logic [31:0] laplacian_variance;

	modport source (output valid, frame_present, has_pixels, timestamp_ms, dark_ratio,
		bright_ratio, laplacian_variance, input ready);
	modport sink (input valid, frame_present, has_pixels, timestamp_ms, dark_ratio,
		bright_ratio, laplacian_variance, output ready);
endinterface

interface chp_status_if;
	logic        valid;
	logic        ready;
	logic        status_valid;
	logic [1:0]  active_issue;
	logic        contamination;
	logic [15:0] suspect_frames;
	logic [16:0] dark_ratio_out;
	logic [16:0] bright_ratio_out;
	logic [31:0] variance_out;

	modport source (output valid, status_valid, active_issue, contamination,
		suspect_frames, dark_ratio_out, bright_ratio_out, variance_out, input ready);
	modport sink (input valid, status_valid, active_issue, contamination,
		suspect_frames, dark_ratio_out, bright_ratio_out, variance_out, output ready);
endinterface

interface chp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/chp_tracker.sv
// Frame classification and issue persistence state; holds the reported status.
module chp_tracker
	import chp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    commit,
	input  frame_t  item,
	input  cfg_t    cfg,
	output status_t held
);

	typedef struct packed {
		logic [TS_W-1:0]  last_time;
		issue_t           pending;
		issue_t           current;
		logic [TS_W-1:0]  pending_since;
		logic [TS_W-1:0]  healthy_since;
		logic [CNT_W-1:0] count;
		status_t          status;
	} trk_state_t;

	trk_state_t state_q;
	trk_state_t state_nxt;

	logic               skip;
	logic [TS_W:0]      gap_d;
	logic [TS_W:0]      heal_d;
	logic [TS_W:0]      pend_d;
	logic [RATIO_W-1:0] dark;
	logic [RATIO_W-1:0] bright;
	logic [VAR_W-1:0]   var_v;
	issue_t             seen;
	logic               activate;

	// Elapsed times against the stored marks; top bit set means time went backwards
	assign gap_d  = {1'b0, item.timestamp_ms} - {1'b0, state_q.last_time};
	assign heal_d = {1'b0, item.timestamp_ms} - {1'b0, state_q.healthy_since};
	assign pend_d = {1'b0, item.timestamp_ms} - {1'b0, state_q.pending_since};

	// Repeat the held status for a missing frame or one inside the interval
	assign skip = !item.frame_present ||
		(state_q.last_time != '0 && !gap_d[TS_W] &&
		 gap_d[TS_W-1:0] < {{(TS_W-MS_W){1'b0}}, cfg.interval_ms});

	// Force the statistics to zero for an empty frame
	assign dark   = item.has_pixels ? item.dark_ratio : '0;
	assign bright = item.has_pixels ? item.bright_ratio : '0;
	assign var_v  = item.has_pixels ? item.laplacian_variance : '0;

	// Classify the frame
	always_comb begin
		if (dark >= cfg.dark_limit || bright >= cfg.bright_limit) begin
			seen = ISSUE_OBSTRUCTION;
		end else if (var_v < cfg.blur_limit) begin
			seen = ISSUE_BLUR;
		end else begin
			seen = ISSUE_NONE;
		end
	end

	// Advance the persistence tracking
	always_comb begin
		state_nxt = state_q;
		activate  = 1'b0;
		if (!skip) begin
			state_nxt.last_time = item.timestamp_ms;
			if (seen == ISSUE_NONE) begin
				state_nxt.pending       = ISSUE_NONE;
				state_nxt.pending_since = '0;
				state_nxt.count         = '0;
				if (state_q.current != ISSUE_NONE) begin
					if (state_q.healthy_since == '0) begin
						state_nxt.healthy_since = item.timestamp_ms;
					end else if (!heal_d[TS_W] && heal_d[TS_W-1:0] >=
							{{(TS_W-MS_W){1'b0}}, cfg.clear_ms}) begin
						state_nxt.current = ISSUE_NONE;
					end
				end else begin
					state_nxt.healthy_since = '0;
				end
			end else begin
				state_nxt.healthy_since = '0;
				state_nxt.pending       = seen;
				if (state_q.pending != seen) begin
					state_nxt.pending_since = item.timestamp_ms;
					state_nxt.count         = CNT_W'(1);
					activate                = (cfg.persist_ms == '0);
				end else begin
					if (state_q.count != '1) begin
						state_nxt.count = state_q.count + CNT_W'(1);
					end
					activate = !pend_d[TS_W] && pend_d[TS_W-1:0] >=
						{{(TS_W-MS_W){1'b0}}, cfg.persist_ms};
				end
				if (activate) begin
					state_nxt.current = seen;
				end
			end
			state_nxt.status.status_valid     = item.has_pixels;
			state_nxt.status.active_issue     = state_nxt.current;
			state_nxt.status.suspect_frames   = state_nxt.count;
			state_nxt.status.dark_ratio_out   = dark;
			state_nxt.status.bright_ratio_out = bright;
			state_nxt.status.variance_out     = var_v;
		end
	end

	// Hold state, update on each committed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (commit) begin
			state_q <= state_nxt;
		end
	end

	assign held = state_q.status;

endmodule

>>> rtl/core/camera_health_persistence.sv
// Top level of the camera health persistence filter.
// Takes one frame statistics record per cycle while the output is not stalled, and returns one
// status record for each, in order. Each record passes an input register, then the classification
// and persistence update, done combinationally against the tracking state, whose result lands
// in the tracker's state and status register that
// drives the output. A new record is taken while a status waits, as long as the input
// register frees up in that cycle. Configuration writes are always accepted and take
// effect on the next record; write them only with no record in flight. Unknown register
// indexes are ignored. There is no clearing pass after reset.
module camera_health_persistence
	import chp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	chp_frame_if.sink     frame,
	chp_status_if.source  status,
	chp_cfg_if.sink       cfg
);

	cfg_t    cfg_q;
	frame_t  item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	logic    commit;
	status_t held;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms  <= '0;
			cfg_q.dark_limit   <= RATIO_ONE;
			cfg_q.bright_limit <= RATIO_ONE;
			cfg_q.blur_limit   <= '0;
			cfg_q.persist_ms   <= '0;
			cfg_q.clear_ms     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_INTERVAL:     cfg_q.interval_ms  <= cfg.data[MS_W-1:0];
				CFG_DARK_LIMIT:   cfg_q.dark_limit   <= cfg.data[RATIO_W-1:0];
				CFG_BRIGHT_LIMIT: cfg_q.bright_limit <= cfg.data[RATIO_W-1:0];
				CFG_BLUR_LIMIT:   cfg_q.blur_limit   <= cfg.data[VAR_W-1:0];
				CFG_PERSIST:      cfg_q.persist_ms   <= cfg.data[MS_W-1:0];
				CFG_CLEAR:        cfg_q.clear_ms     <= cfg.data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Status register frees when empty or its transfer completes
	assign advance     = !out_valid_q || status.ready;
	assign commit      = valid_s1 && advance;
	assign frame.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			item_s1.frame_present      <= frame.frame_present;
			item_s1.has_pixels         <= frame.has_pixels;
			item_s1.timestamp_ms       <= frame.timestamp_ms;
			item_s1.dark_ratio         <= frame.dark_ratio;
			item_s1.bright_ratio       <= frame.bright_ratio;
			item_s1.laplacian_variance <= frame.laplacian_variance;
		end
	end

	// Classification, persistence state and held status
	chp_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.item   (item_s1),
		.cfg    (cfg_q),
		.held   (held)
	);

	// Output valid follows the held status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	assign status.valid            = out_valid_q;
	assign status.status_valid     = held.status_valid;
	assign status.active_issue     = held.active_issue;
	assign status.contamination    = (held.active_issue != ISSUE_NONE);
	assign status.suspect_frames   = held.suspect_frames;
	assign status.dark_ratio_out   = held.dark_ratio_out;
	assign status.bright_ratio_out = held.bright_ratio_out;
	assign status.variance_out     = held.variance_out;

	// A status appears only for a record that sat in the input register
	a_status_from_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("status raised without an input record");

	// A record waiting in the input register is never dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a waiting record");

	// A full pipeline with a stalled output takes no new record
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !status.ready |-> !frame.ready)
		else $error("record accepted into a full pipeline");

endmodule

>>> dv/camera_health_persistence_tb.sv
// Self-checking testbench for the camera health persistence filter.
module camera_health_persistence_tb
	import chp_pkg::*;
();

	localparam int unsigned SETTLE      = 4;     // cycles after the last status before a write
	localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
	localparam int unsigned HOLD_AT     = 600;   // status count at which the sink holds off
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_LEN   = 235;

	// Register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Track issue persistence and the held status, one status per frame
	class chp_status_board;
		cfg_t               regs;
		status_t            shown;
		status_t            status_due[$];
		logic [TS_W-1:0]    t_last;
		logic [TS_W-1:0]    cand_since;
		logic [TS_W-1:0]    calm_since;
		issue_t             cand_issue;
		issue_t             live_issue;
		logic [CNT_W-1:0]   run_len;
		int unsigned        frames, analysed, checked, errors;
		int unsigned        obstructed, blurred, longest;

		function new();
			regs.interval_ms  = '0;
			regs.dark_limit   = RATIO_ONE;
			regs.bright_limit = RATIO_ONE;
			regs.blur_limit   = '0;
			regs.persist_ms   = '0;
			regs.clear_ms     = '0;
			shown      = '0;
			t_last     = '0;
			cand_since = '0;
			calm_since = '0;
			cand_issue = ISSUE_NONE;
			live_issue = ISSUE_NONE;
			run_len    = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_INTERVAL:     regs.interval_ms  = data[MS_W-1:0];
				CFG_DARK_LIMIT:   regs.dark_limit   = data[RATIO_W-1:0];
				CFG_BRIGHT_LIMIT: regs.bright_limit = data[RATIO_W-1:0];
				CFG_BLUR_LIMIT:   regs.blur_limit   = data[VAR_W-1:0];
				CFG_PERSIST:      regs.persist_ms   = data[MS_W-1:0];
				CFG_CLEAR:        regs.clear_ms     = data[MS_W-1:0];
				default: ;
			endcase
		endfunction

		// A backwards step in time never counts as having lasted
		function bit lasted(logic [TS_W-1:0] now, logic [TS_W-1:0] since, logic [MS_W-1:0] span);
			return (now >= since) && ((now - since) >= span);
		endfunction

		// Advance the suspect and active issue for one classified frame
		function void follow(issue_t seen, logic [TS_W-1:0] ts);
			if (seen == ISSUE_NONE) begin
				cand_issue = ISSUE_NONE;
				cand_since = '0;
				run_len    = '0;
				if (live_issue == ISSUE_NONE)
					calm_since = '0;
				else if (calm_since == '0)
					calm_since = ts;
				else if (lasted(ts, calm_since, regs.clear_ms))
					live_issue = ISSUE_NONE;
			end else begin
				calm_since = '0;
				if (cand_issue != seen) begin
					cand_issue = seen;
					cand_since = ts;
					run_len    = CNT_W'(1);
				end else if (run_len != '1) begin
					run_len = run_len + 1'b1;
				end
				if (lasted(ts, cand_since, regs.persist_ms))
					live_issue = cand_issue;
			end
		endfunction

		// Note an accepted frame and queue the status it yields
		function void take_frame(frame_t f);
			logic [RATIO_W-1:0] dk, br;
			logic [VAR_W-1:0]   vr;
			issue_t             seen;
			bit                 skip;
			skip = !f.frame_present || (t_last != '0 && f.timestamp_ms >= t_last &&
				(f.timestamp_ms - t_last) < regs.interval_ms);
			if (!skip) begin
				t_last = f.timestamp_ms;
				dk = f.has_pixels ? f.dark_ratio : '0;
				br = f.has_pixels ? f.bright_ratio : '0;
				vr = f.has_pixels ? f.laplacian_variance : '0;
				if (dk >= regs.dark_limit || br >= regs.bright_limit)
					seen = ISSUE_OBSTRUCTION;
				else if (vr < regs.blur_limit)
					seen = ISSUE_BLUR;
				else
					seen = ISSUE_NONE;
				follow(seen, f.timestamp_ms);
				shown.status_valid     = f.has_pixels;
				shown.active_issue     = live_issue;
				shown.suspect_frames   = run_len;
				shown.dark_ratio_out   = dk;
				shown.bright_ratio_out = br;
				shown.variance_out     = vr;
				analysed++;
			end
			status_due.insert(status_due.size(), shown);
			frames++;
			if (shown.active_issue == ISSUE_OBSTRUCTION) obstructed++;
			if (shown.active_issue == ISSUE_BLUR) blurred++;
			if (32'(shown.suspect_frames) > longest) longest = 32'(shown.suspect_frames);
		endfunction

		task report(string what, logic [63:0] want, logic [63:0] got);
			errors++;
			if (errors <= 40)
				$display("status %0d: %s expected %0h, got %0h", checked, what, want, got);
		endtask

		// Compare one status transfer with the oldest queued status
		task match_status(status_t got, logic contam);
			status_t want;
			checked++;
			if (status_due.size() == 0) begin
				report("status with no frame waiting", '0, '0);
			end else begin
				want = status_due[0];
				status_due.delete(0);
				if (got.status_valid !== want.status_valid)
					report("status_valid", want.status_valid, got.status_valid);
				if (got.active_issue !== want.active_issue)
					report("active_issue", want.active_issue, got.active_issue);
				if (contam !== (want.active_issue != ISSUE_NONE))
					report("contamination", want.active_issue != ISSUE_NONE, contam);
				if (got.suspect_frames !== want.suspect_frames)
					report("suspect_frames", want.suspect_frames, got.suspect_frames);
				if (got.dark_ratio_out !== want.dark_ratio_out)
					report("dark_ratio_out", want.dark_ratio_out, got.dark_ratio_out);
				if (got.bright_ratio_out !== want.bright_ratio_out)
					report("bright_ratio_out", want.bright_ratio_out, got.bright_ratio_out);
				if (got.variance_out !== want.variance_out)
					report("variance_out", want.variance_out, got.variance_out);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	chp_frame_if  frame_ch();
	chp_status_if status_ch();
	chp_cfg_if    cfg_ch();

	camera_health_persistence i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	chp_status_board board = new();

	logic [TS_W-1:0] ts_now = 48'd1000;
	int unsigned     ms_span = 3;
	int unsigned     run_kind, run_left;
	int unsigned     settings;
	int unsigned     quiet;
	bit              src_calm, sink_calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stop when no channel has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (frame_ch.valid && frame_ch.ready) ||
		    (status_ch.valid && status_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("camera_health_persistence: mismatch");
			$finish;
		end
	end

	// Status sink: random stalls per transfer, one long hold-off
	initial begin : status_side
		int unsigned stall;
		int unsigned results;
		status_t     got;
		stall   = 0;
		results = 0;
		status_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (status_ch.valid && status_ch.ready) begin
				got.status_valid     = status_ch.status_valid;
				got.active_issue     = issue_t'(status_ch.active_issue);
				got.suspect_frames   = status_ch.suspect_frames;
				got.dark_ratio_out   = status_ch.dark_ratio_out;
				got.bright_ratio_out = status_ch.bright_ratio_out;
				got.variance_out     = status_ch.variance_out;
				board.match_status(got, status_ch.contamination);
				results++;
				if (results % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
				if (results == HOLD_AT)
					stall = HOLD_CYCLES;
				else
					stall = sink_calm ? 0 : $urandom_range(0, 15);
			end
			status_ch.ready <= (stall == 0);
			if (stall != 0) stall--;
		end
	end

	function automatic frame_t frm(logic present, logic pix, logic [TS_W-1:0] ts,
		logic [RATIO_W-1:0] dk, logic [RATIO_W-1:0] br, logic [VAR_W-1:0] vr);
		frame_t f;
		f.frame_present      = present;
		f.has_pixels         = pix;
		f.timestamp_ms       = ts;
		f.dark_ratio         = dk;
		f.bright_ratio       = br;
		f.laplacian_variance = vr;
		return f;
	endfunction

	function automatic logic [31:0] pick_below(logic [31:0] lim);
		if (lim == 0) return 0;
		return ($urandom_range(0, 3) == 0) ? lim - 1 : $urandom_range(0, lim - 1);
	endfunction

	function automatic logic [31:0] pick_from(logic [31:0] lim, logic [31:0] top);
		return ($urandom_range(0, 3) == 0) ? lim : $urandom_range(lim, top);
	endfunction

	// Build a frame: runs of one class around the limits, some noise and time jumps
	function automatic frame_t random_frame();
		frame_t      f;
		int unsigned roll;
		f.frame_present = ($urandom_range(0, 15) != 0);
		f.has_pixels    = ($urandom_range(0, 19) != 0);
		roll = $urandom_range(0, 99);
		if (roll < 82)
			ts_now = ts_now + $urandom_range(0, ms_span);
		else if (roll < 89)
			ts_now = (ts_now > ms_span) ? ts_now - $urandom_range(1, ms_span) : ts_now;
		else if (roll < 94)
			ts_now = ts_now + $urandom;
		else if (roll < 97)
			ts_now = {16'($urandom), $urandom};
		f.timestamp_ms = (roll >= 97) ? '0 : ts_now;

		if (run_left == 0) begin
			run_kind = $urandom_range(0, 3);
			run_left = $urandom_range(1, 12);
		end
		run_left--;
		if ($urandom_range(0, 99) < 15) begin
			f.dark_ratio         = 17'($urandom);
			f.bright_ratio       = 17'($urandom);
			f.laplacian_variance = $urandom;
		end else begin
			f.dark_ratio         = 17'(pick_below(board.regs.dark_limit));
			f.bright_ratio       = 17'(pick_below(board.regs.bright_limit));
			f.laplacian_variance = pick_from(board.regs.blur_limit, 32'hFFFF_FFFF);
			case (run_kind)
				1: f.dark_ratio = 17'(pick_from(board.regs.dark_limit, 32'h1FFFF));
				2: f.bright_ratio = 17'(pick_from(board.regs.bright_limit, 32'h1FFFF));
				3: f.laplacian_variance = pick_below(board.regs.blur_limit);
				default: ;
			endcase
		end
		return f;
	endfunction

	// Offer one frame after a random gap; hold valid high across back-to-back frames
	task automatic send_frame(frame_t f);
		int unsigned gap;
		gap = src_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid              <= 1'b1;
		frame_ch.frame_present      <= f.frame_present;
		frame_ch.has_pixels         <= f.has_pixels;
		frame_ch.timestamp_ms       <= f.timestamp_ms;
		frame_ch.dark_ratio         <= f.dark_ratio;
		frame_ch.bright_ratio       <= f.bright_ratio;
		frame_ch.laplacian_variance <= f.laplacian_variance;
		do @(posedge clk); while (!frame_ch.ready);
		board.take_frame(f);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_reg(idx, data);
	endtask

	// Drain the block, then write every register and one undecoded index
	task automatic load_regs(logic [31:0] ivl, logic [31:0] dk, logic [31:0] br,
		logic [31:0] blur, logic [31:0] per, logic [31:0] clr);
		frame_ch.valid <= 1'b0;
		while (board.status_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_write(CFG_INTERVAL, ivl);
		cfg_write(CFG_DARK_LIMIT, dk);
		cfg_write(CFG_BRIGHT_LIMIT, br);
		cfg_write(CFG_BLUR_LIMIT, blur);
		cfg_write(CFG_PERSIST, per);
		cfg_write(CFG_CLEAR, clr);
		cfg_write(settings[0] ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
		cfg_ch.valid <= 1'b0;
		settings++;
		ms_span = 32'(board.regs.interval_ms);
		if (board.regs.persist_ms > ms_span) ms_span = 32'(board.regs.persist_ms);
		if (board.regs.clear_ms > ms_span) ms_span = 32'(board.regs.clear_ms);
		ms_span = ms_span / 3 + 3;
	endtask

	initial begin
		arst_n = 1'b0;
		frame_ch.valid              <= 1'b0;
		frame_ch.frame_present      <= 1'b0;
		frame_ch.has_pixels         <= 1'b0;
		frame_ch.timestamp_ms       <= '0;
		frame_ch.dark_ratio         <= '0;
		frame_ch.bright_ratio       <= '0;
		frame_ch.laplacian_variance <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: status before any analysis, pixel-less frame, instant set and clear
		send_frame(frm(1'b0, 1'b1, 48'd7, 17'd65536, 17'd65536, 32'hFFFF_FFFF));
		send_frame(frm(1'b1, 1'b0, 48'd0, 17'd65536, 17'd65536, 32'hFFFF_FFFF));
		send_frame(frm(1'b1, 1'b1, 48'd5, 17'd65536, 17'd0, 32'd12));
		send_frame(frm(1'b1, 1'b1, 48'd5, 17'd0, 17'h1FFFF, 32'd12));
		send_frame(frm(1'b1, 1'b1, 48'd6, 17'd65535, 17'd65535, 32'd0));
		send_frame(frm(1'b1, 1'b1, 48'd6, 17'd65535, 17'd65535, 32'd0));

		// Interval hold, persistence, blur takeover, clearing and time going backwards
		load_regs(10, 40000, 50000, 1000, 20, 30);
		send_frame(frm(1'b1, 1'b1, 48'd100, 17'd40000, 17'd0, 32'd5000));
		send_frame(frm(1'b1, 1'b1, 48'd105, 17'd40000, 17'd0, 32'd5000));
		send_frame(frm(1'b1, 1'b1, 48'd110, 17'd39999, 17'd50000, 32'd5000));
		send_frame(frm(1'b0, 1'b1, 48'd111, 17'd0, 17'd0, 32'd0));
		send_frame(frm(1'b1, 1'b1, 48'd120, 17'd40001, 17'd0, 32'd5000));
		send_frame(frm(1'b1, 1'b1, 48'd130, 17'd0, 17'd0, 32'd999));
		send_frame(frm(1'b1, 1'b1, 48'd150, 17'd0, 17'd0, 32'd0));
		send_frame(frm(1'b1, 1'b1, 48'd160, 17'd39999, 17'd49999, 32'd1000));
		send_frame(frm(1'b1, 1'b1, 48'd175, 17'd0, 17'd0, 32'd1000));
		send_frame(frm(1'b1, 1'b1, 48'd50, 17'd0, 17'd0, 32'd1000));
		send_frame(frm(1'b1, 1'b1, 48'd195, 17'd0, 17'd0, 32'd1000));
		send_frame(frm(1'b1, 1'b1, 48'd0, 17'd65536, 17'd0, 32'd1000));
		send_frame(frm(1'b1, 1'b0, 48'd3, 17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF));
		send_frame(frm(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 17'd0, 17'd0, 32'hFFFF_FFFF));
		send_frame(frm(1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 17'd65536, 17'd0, 32'd0));

		// Random phases over reset, all-ones, all-zero, moderate and full-range settings
		for (int k = 0; k < 8; k++) begin
			case (k)
				0: load_regs(0, 65536, 65536, 0, 0, 0);
				1: load_regs('1, '1, '1, '1, '1, '1);
				2: load_regs(0, 0, 0, 0, 0, 0);
				6: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: load_regs($urandom_range(0, 40), $urandom_range(16384, 65536),
					$urandom_range(16384, 65536), $urandom_range(0, 200000),
					$urandom_range(0, 120), $urandom_range(0, 120));
			endcase
			for (int unsigned n = 0; n < PHASE_LEN; n++) begin
				if (n % 40 == 0) src_calm = ($urandom_range(0, 3) == 0);
				send_frame(random_frame());
			end
		end

		frame_ch.valid <= 1'b0;
		while (board.status_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("summary: %0d frames (%0d classified), %0d statuses checked, %0d register loads",
			board.frames, board.analysed, board.checked, settings);
		$display("summary: obstruction held in %0d statuses, blur in %0d, longest suspect run %0d",
			board.obstructed, board.blurred, board.longest);
		if (board.errors == 0)
			$display("camera_health_persistence: match");
		else
			$display("camera_health_persistence: mismatch");
		$finish;
	end

endmodule

>>> camera_health_persistence.f
rtl/core/chp_pkg.sv
rtl/core/chp_ifs.sv
rtl/core/chp_tracker.sv
rtl/core/camera_health_persistence.sv
dv/camera_health_persistence_tb.sv
